// File: rtl/bcpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell protection monitor package
// Shared widths, request codes, register indexes, reset values and the
// record types passed between the monitor's modules.
// ----------------------------------------------------------------------------
package bcpm_pkg;

  // Number of monitored cells and the widths that follow from it
  localparam int NUM_CELLS = 5;
  localparam int CELL_IDX_W = 3;
  localparam int CNT_W = $clog2(NUM_CELLS + 1);

  localparam int MV_W = 16;
  localparam int TEMP_W = 16;
  localparam int ERR_W = 8;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // Request codes
  localparam logic [OP_W-1:0] OP_CELL  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
  localparam logic [OP_W-1:0] OP_FAIL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OV_TRIP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OV_RECOVER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UV_TRIP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UV_RECOVER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OT_TRIP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OT_RECOVER = 3'd5;

  // Reset values of the thresholds
  localparam logic [MV_W-1:0] OV_TRIP_RST    = 16'd4200;
  localparam logic [MV_W-1:0] OV_RECOVER_RST = 16'd4100;
  localparam logic [MV_W-1:0] UV_TRIP_RST    = 16'd3000;
  localparam logic [MV_W-1:0] UV_RECOVER_RST = 16'd3100;
  localparam logic signed [TEMP_W-1:0] OT_TRIP_RST    = 16'sd600;
  localparam logic signed [TEMP_W-1:0] OT_RECOVER_RST = 16'sd500;

  typedef struct packed {
    logic [MV_W-1:0]          ov_trip;
    logic [MV_W-1:0]          ov_recover;
    logic [MV_W-1:0]          uv_trip;
    logic [MV_W-1:0]          uv_recover;
    logic signed [TEMP_W-1:0] ot_trip;
    logic signed [TEMP_W-1:0] ot_recover;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [CELL_IDX_W-1:0]    cell_index;
    logic [MV_W-1:0]          cell_mv;
    logic signed [TEMP_W-1:0] temperature;
  } item_t;

  typedef struct packed {
    logic                     frame_ok;
    logic                     ov_fault;
    logic                     uv_fault;
    logic                     ot_fault;
    logic                     charge_enable;
    logic                     discharge_enable;
    logic [NUM_CELLS-1:0]     ov_cell_map;
    logic [NUM_CELLS-1:0]     uv_cell_map;
    logic [CNT_W-1:0]         ov_count;
    logic [CNT_W-1:0]         uv_count;
    logic signed [TEMP_W-1:0] latched_hot_temp;
    logic [ERR_W-1:0]         error_count;
  } result_t;

  // Count the set bits of a cell map
  function automatic logic [CNT_W-1:0] count_ones(input logic [NUM_CELLS-1:0] map);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      n = n + CNT_W'(map[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/bcpm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold register file
// Holds the six trip and recovery thresholds, written one at a time
// through the configuration channel.
// ----------------------------------------------------------------------------
module bcpm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [bcpm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bcpm_pkg::CFG_DATA_W-1:0]  wr_data,
  output bcpm_pkg::cfg_t                   cfg
);

  bcpm_pkg::cfg_t regs;
  bcpm_pkg::cfg_t regs_next;

  // Decode the write onto its register
  always_comb begin
    regs_next = regs;
    if (wr_en) begin
      unique case (wr_index)
        bcpm_pkg::REG_OV_TRIP:    regs_next.ov_trip    = wr_data;
        bcpm_pkg::REG_OV_RECOVER: regs_next.ov_recover = wr_data;
        bcpm_pkg::REG_UV_TRIP:    regs_next.uv_trip    = wr_data;
        bcpm_pkg::REG_UV_RECOVER: regs_next.uv_recover = wr_data;
        bcpm_pkg::REG_OT_TRIP:    regs_next.ot_trip    = $signed(wr_data);
        bcpm_pkg::REG_OT_RECOVER: regs_next.ot_recover = $signed(wr_data);
        default: ;
      endcase
    end
  end

  // Hold the thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ov_trip    <= bcpm_pkg::OV_TRIP_RST;
      regs.ov_recover <= bcpm_pkg::OV_RECOVER_RST;
      regs.uv_trip    <= bcpm_pkg::UV_TRIP_RST;
      regs.uv_recover <= bcpm_pkg::UV_RECOVER_RST;
      regs.ot_trip    <= bcpm_pkg::OT_TRIP_RST;
      regs.ot_recover <= bcpm_pkg::OT_RECOVER_RST;
    end else begin
      regs <= regs_next;
    end
  end

  assign cfg = regs;

endmodule

// File: rtl/bcpm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault evaluation core
// Applies one request to the protection state: cell compares with
// hysteresis, frame commit, read-failure count, and builds the report.
// ----------------------------------------------------------------------------
module bcpm_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  bcpm_pkg::item_t  item,
  input  bcpm_pkg::cfg_t   cfg,
  output bcpm_pkg::result_t report
);

  logic                               fault_ov, fault_ov_next;
  logic                               fault_uv, fault_uv_next;
  logic                               fault_ot, fault_ot_next;
  logic [bcpm_pkg::NUM_CELLS-1:0]     pending_ov, pending_ov_next;
  logic [bcpm_pkg::NUM_CELLS-1:0]     pending_uv, pending_uv_next;
  logic [bcpm_pkg::NUM_CELLS-1:0]     held_ov, held_ov_next;
  logic [bcpm_pkg::NUM_CELLS-1:0]     held_uv, held_uv_next;
  logic signed [bcpm_pkg::TEMP_W-1:0] hot_latch, hot_latch_next;
  logic [bcpm_pkg::ERR_W-1:0]         fail_cnt, fail_cnt_next;

  logic [bcpm_pkg::MV_W-1:0]          ov_th;
  logic [bcpm_pkg::MV_W-1:0]          uv_th;
  logic signed [bcpm_pkg::TEMP_W-1:0] ot_th;
  logic [bcpm_pkg::NUM_CELLS-1:0]     cell_bit;
  logic                               cell_in_range;
  logic                               ot_hit;

  // Pick recovery or trip level from the committed faults
  assign ov_th = fault_ov ? cfg.ov_recover : cfg.ov_trip;
  assign uv_th = fault_uv ? cfg.uv_recover : cfg.uv_trip;
  assign ot_th = fault_ot ? cfg.ot_recover : cfg.ot_trip;

  assign cell_in_range = (int'(item.cell_index) < bcpm_pkg::NUM_CELLS);
  assign cell_bit      = bcpm_pkg::NUM_CELLS'(1) << item.cell_index;
  assign ot_hit        = ($signed(item.temperature) > ot_th);

  // Work out the state after this request
  always_comb begin
    fault_ov_next   = fault_ov;
    fault_uv_next   = fault_uv;
    fault_ot_next   = fault_ot;
    pending_ov_next = pending_ov;
    pending_uv_next = pending_uv;
    held_ov_next    = held_ov;
    held_uv_next    = held_uv;
    hot_latch_next  = hot_latch;
    fail_cnt_next   = fail_cnt;
    if (go) begin
      case (item.opcode)
        bcpm_pkg::OP_CELL: begin
          if (cell_in_range) begin
            pending_ov_next = (item.cell_mv > ov_th) ? (pending_ov | cell_bit)
                                                     : (pending_ov & ~cell_bit);
            pending_uv_next = (item.cell_mv < uv_th) ? (pending_uv | cell_bit)
                                                     : (pending_uv & ~cell_bit);
          end
        end
        bcpm_pkg::OP_CLOSE: begin
          fault_ov_next   = (pending_ov != '0);
          fault_uv_next   = (pending_uv != '0);
          fault_ot_next   = ot_hit;
          held_ov_next    = pending_ov;
          held_uv_next    = pending_uv;
          pending_ov_next = '0;
          pending_uv_next = '0;
          fail_cnt_next   = '0;
          if (ot_hit) begin
            hot_latch_next = item.temperature;
          end
        end
        bcpm_pkg::OP_FAIL: begin
          pending_ov_next = '0;
          pending_uv_next = '0;
          if (fail_cnt != bcpm_pkg::ERR_MAX) begin
            fail_cnt_next = fail_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the protection state
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_ov   <= 1'b0;
      fault_uv   <= 1'b0;
      fault_ot   <= 1'b0;
      pending_ov <= '0;
      pending_uv <= '0;
      held_ov    <= '0;
      held_uv    <= '0;
      hot_latch  <= '0;
      fail_cnt   <= '0;
    end else begin
      fault_ov   <= fault_ov_next;
      fault_uv   <= fault_uv_next;
      fault_ot   <= fault_ot_next;
      pending_ov <= pending_ov_next;
      pending_uv <= pending_uv_next;
      held_ov    <= held_ov_next;
      held_uv    <= held_uv_next;
      hot_latch  <= hot_latch_next;
      fail_cnt   <= fail_cnt_next;
    end
  end

  // Build the report from the updated state
  always_comb begin
    report.frame_ok         = (item.opcode == bcpm_pkg::OP_CLOSE);
    report.ov_fault         = fault_ov_next;
    report.uv_fault         = fault_uv_next;
    report.ot_fault         = fault_ot_next;
    report.charge_enable    = !fault_ot_next && !fault_ov_next;
    report.discharge_enable = !fault_ot_next && !fault_uv_next;
    report.ov_cell_map      = held_ov_next;
    report.uv_cell_map      = held_uv_next;
    report.ov_count         = bcpm_pkg::count_ones(held_ov_next);
    report.uv_count         = bcpm_pkg::count_ones(held_uv_next);
    report.latched_hot_temp = hot_latch_next;
    report.error_count      = fail_cnt_next;
  end

endmodule

// File: rtl/battery_cell_protection_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell protection monitor
// Over-voltage, under-voltage and over-temperature protection with
// hysteresis, driven by measurement frames.
// ----------------------------------------------------------------------------
// Every request passes an input register and one evaluation step; the
// report of a frame close or read failure goes to the report register
// when that step runs. One request is taken per cycle as long as reports
// drain. A cell sample leaves the input register in the cycle after it is
// taken; a frame close or read failure stays there, and holds off the
// requests behind it, only while the report register is full and not
// being taken. The thresholds are written through the cfg channel, which
// is always ready, and should be changed only while no request is in
// flight.
module battery_cell_protection_monitor (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bcpm_pkg::OP_W-1:0]         opcode,
  input  logic [bcpm_pkg::CELL_IDX_W-1:0]   cell_index,
  input  logic [bcpm_pkg::MV_W-1:0]         cell_mv,
  input  logic signed [bcpm_pkg::TEMP_W-1:0] temperature,
  // report channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              frame_ok,
  output logic                              ov_fault,
  output logic                              uv_fault,
  output logic                              ot_fault,
  output logic                              charge_enable,
  output logic                              discharge_enable,
  output logic [bcpm_pkg::NUM_CELLS-1:0]    ov_cell_map,
  output logic [bcpm_pkg::NUM_CELLS-1:0]    uv_cell_map,
  output logic [bcpm_pkg::CNT_W-1:0]        ov_count,
  output logic [bcpm_pkg::CNT_W-1:0]        uv_count,
  output logic signed [bcpm_pkg::TEMP_W-1:0] latched_hot_temp,
  output logic [bcpm_pkg::ERR_W-1:0]        error_count,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bcpm_pkg::cfg_t    cfg;
  bcpm_pkg::item_t   item;
  bcpm_pkg::result_t report;
  bcpm_pkg::result_t result;

  logic item_valid;
  logic needs_out;
  logic out_free;
  logic go;

  // Threshold registers
  assign cfg_ready = 1'b1;

  bcpm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage control: cell samples never need the report register
  assign needs_out = (item.opcode == bcpm_pkg::OP_CLOSE) ||
                     (item.opcode == bcpm_pkg::OP_FAIL);
  assign out_free  = !out_valid || out_ready;
  assign go        = item_valid && (!needs_out || out_free);
  assign in_ready  = !item_valid || go;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.opcode      <= opcode;
      item.cell_index  <= cell_index;
      item.cell_mv     <= cell_mv;
      item.temperature <= temperature;
    end
  end

  // Evaluate against the protection state
  bcpm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item),
    .cfg    (cfg),
    .report (report)
  );

  // Hold the report until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && needs_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && needs_out) begin
      result <= report;
    end
  end

  assign frame_ok         = result.frame_ok;
  assign ov_fault         = result.ov_fault;
  assign uv_fault         = result.uv_fault;
  assign ot_fault         = result.ot_fault;
  assign charge_enable    = result.charge_enable;
  assign discharge_enable = result.discharge_enable;
  assign ov_cell_map      = result.ov_cell_map;
  assign uv_cell_map      = result.uv_cell_map;
  assign ov_count         = result.ov_count;
  assign uv_count         = result.uv_count;
  assign latched_hot_temp = result.latched_hot_temp;
  assign error_count      = result.error_count;

  // A frame close yields a good-frame report with a cleared error count
  a_close_report: assert property (@(posedge clk) disable iff (rst)
    go && (item.opcode == bcpm_pkg::OP_CLOSE) |=>
      out_valid && frame_ok && (error_count == '0))
    else $error("frame close did not produce a good-frame report");

  // A read failure yields a failure report with a nonzero error count
  a_fail_report: assert property (@(posedge clk) disable iff (rst)
    go && (item.opcode == bcpm_pkg::OP_FAIL) |=>
      out_valid && !frame_ok && (error_count != '0))
    else $error("read failure did not produce a failure report");

  // Fault flags agree with the reported cell maps
  a_maps_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ov_fault == (ov_cell_map != '0)) && (uv_fault == (uv_cell_map != '0)))
    else $error("fault flag disagrees with cell map");

  // Enables are off whenever over-temperature is reported
  a_ot_enables: assert property (@(posedge clk) disable iff (rst)
    out_valid && ot_fault |-> !charge_enable && !discharge_enable)
    else $error("switch enabled during over-temperature");

endmodule
